/* rtl/core/psdq_pkg.sv */
// Package for the phase second-difference quality block.
// Holds widths, register indexes, command and status structs.
// No dependencies.
package psdq_pkg;

    localparam int SAMPLE_W     = 24;
    localparam int DIFF_W       = 26;
    localparam int SUM_W        = 52;
    localparam int Q_W          = 26;
    localparam int PLANE_W      = 16;
    localparam int GEOM_W       = 7;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANES = 2'd2;

    localparam logic [GEOM_W-1:0]  COLS_RESET   = 7'd64;
    localparam logic [GEOM_W-1:0]  ROWS_RESET   = 7'd64;
    localparam logic [PLANE_W-1:0] PLANES_RESET = 16'd64;

    typedef enum logic [2:0] {
        A_C  = 3'd0,
        A_XP = 3'd1,
        A_XM = 3'd2,
        A_YP = 3'd3,
        A_YM = 3'd4
    } t_addr;

    typedef struct packed {
        logic  accept;
        t_addr addr;
        logic  lat_c;
        logic  lat_a;
        logic  dx;
        logic  dy;
        logic  dz;
        logic  sq;
        logic  sum_init;
        logic  acc;
        logic  min_wr;
        logic  mem_wr;
        logic  root_start;
        logic  root_sel;
        logic  lat_q;
        logic  lat_mq;
        logic  load_out;
    } t_cmd;

    typedef struct packed {
        logic use_v;
        logic last_v;
        logic root_done;
        logic out_free;
    } t_sts;

endpackage

/* rtl/core/psdq_in_if.sv */
// Input channel: one phase sample word per handshake.
// Depends on psdq_pkg.
interface psdq_in_if import psdq_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] phase_sample;

    modport source (output valid, output phase_sample, input ready);
    modport sink   (input valid, input phase_sample, output ready);
endinterface

/* rtl/core/psdq_out_if.sv */
// Output channel: one quality word per handshake.
// Depends on psdq_pkg.
interface psdq_out_if import psdq_pkg::*; ();
    logic           valid;
    logic           ready;
    logic [Q_W-1:0] quality;
    logic [Q_W-1:0] min_quality;
    logic           final_flag;

    modport source (output valid, output quality, output min_quality, output final_flag,
                    input ready);
    modport sink   (input valid, input quality, input min_quality, input final_flag,
                    output ready);
endinterface

/* rtl/core/phase_second_difference_quality.sv */
// Top level of the phase second-difference quality block.
// Depends on psdq_pkg, psdq_in_if, psdq_out_if, psdq_ctrl, psdq_dp.
//
// Usage:
//   i_in carries one phase voxel word per handshake, raster order, x fastest.
//   o_out carries one quality word per interior voxel, with min_quality and
//   final_flag set on the last result of the volume.
//   i_cfg_we/i_cfg_idx/i_cfg_data write cols, rows, planes; a write to any
//   of these restarts the volume. Write only while the block is idle.
// Flow:
//   A voxel that gives no result reads its store words, writes back and
//   returns to ready. A voxel that gives a result goes on through the
//   difference and sum arithmetic and the one-bit-per-cycle square root
//   unit to the output register; the last voxel also roots the minimum.
//   One voxel is in work at a time; the output register holds a finished
//   word while the next voxel is accepted.
// Reset: counters clear, minimum returns to all ones, stores keep contents.
// Stall: a held output word blocks the next result hand-off, and with it the input.
module phase_second_difference_quality import psdq_pkg::*; #(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    psdq_in_if.sink               i_in,
    psdq_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    t_cmd cmd;
    t_sts sts;
    logic ready;

    psdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    psdq_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_sample      (i_in.phase_sample),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_out.valid),
        .i_ready       (o_out.ready),
        .o_quality     (o_out.quality),
        .o_min_quality (o_out.min_quality),
        .o_final_flag  (o_out.final_flag)
    );

    assign i_in.ready = ready;

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && ready) |=> !ready)
        else $error("ready held after accepting a word");

    a_min_only_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.final_flag) |-> (o_out.min_quality == '0))
        else $error("min_quality set on a non-final word");

    a_root_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.root_done |-> !ready)
        else $error("root finished while controller idle");
`endif
endmodule

/* rtl/core/psdq_sqrt.sv */
// Iterative floor square root, one result bit per cycle.
// Depends on psdq_pkg.
module psdq_sqrt import psdq_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_value,
    output logic [Q_W-1:0]   o_root,
    output logic             o_done
);
    localparam int CNT_W = $clog2(Q_W);
    localparam int REM_W = Q_W + 3;

    logic [SUM_W-1:0] r_rad;
    logic [REM_W-1:0] r_rem;
    logic [Q_W-1:0]   r_root;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [REM_W-1:0] n_rem;
    logic [REM_W-1:0] trial;
    logic             ge;

    always_comb begin
        n_rem = {r_rem[Q_W:0], r_rad[SUM_W-1 -: 2]};
        trial = {1'b0, r_root, 2'b01};
        ge    = n_rem >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rad  <= i_value;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CNT_W'(Q_W - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= ge ? n_rem - trial : n_rem;
                r_root <= {r_root[Q_W-2:0], ge};
                r_rad  <= {r_rad[SUM_W-3:0], 2'b00};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;
endmodule

/* rtl/core/psdq_dp.sv */
// Datapath: plane stores, voxel counters, difference and sum arithmetic,
// minimum tracking and output register. Depends on psdq_pkg, psdq_sqrt.
module psdq_dp import psdq_pkg::*; #(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_sts                       o_sts,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [Q_W-1:0]             o_quality,
    output logic [Q_W-1:0]             o_min_quality,
    output logic                       o_final_flag
);
    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW     = $clog2(MAX_COLS);
    localparam int YW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam logic [SUM_W-1:0] SUM_ONES = '1;

    logic [SAMPLE_W-1:0] rmem [DEPTH];
    logic [SAMPLE_W-1:0] omem [DEPTH];

    logic [GEOM_W-1:0]  r_cols, r_rows;
    logic [PLANE_W-1:0] r_planes;
    logic [XW-1:0]      r_col;
    logic [YW-1:0]      r_row;
    logic [PLANE_W-1:0] r_plane;

    logic signed [SAMPLE_W-1:0] r_s, r_c, r_old, r_a, r_rd, r_od;
    logic [AW-1:0]              r_idx, raddr;
    logic                       r_use, r_last, r_two;
    logic signed [DIFF_W-1:0]   r_d;
    logic [SUM_W-1:0]           r_sq, r_sum, r_least;
    logic [Q_W-1:0]             r_q, r_mq;
    logic                       r_ov;
    logic [Q_W-1:0]             r_oq, r_omq;
    logic                       r_of;

    logic [31:0] ec, er, ep, xv, yv, zv, idxv;
    logic        two, use_n, last_n;
    logic signed [DIFF_W-1:0]   d_ab, d_z;
    logic signed [PROD_W-1:0]   prod;
    logic [Q_W-1:0]             root;
    logic                       root_done;

    function automatic logic signed [DIFF_W-1:0] sdiff(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b,
        input logic signed [SAMPLE_W-1:0] c
    );
        sdiff = DIFF_W'(a) + DIFF_W'(b) - (DIFF_W'(c) <<< 1);
    endfunction

    function automatic logic i_valid_pop();
        i_valid_pop = r_ov && i_ready;
    endfunction

    always_comb begin
        ec = (r_cols == '0) ? 32'd1 :
             ((32'(r_cols) > 32'(MAX_COLS)) ? 32'(MAX_COLS) : 32'(r_cols));
        er = (r_rows == '0) ? 32'd1 :
             ((32'(r_rows) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : 32'(r_rows));
        ep = (r_planes == '0) ? 32'd1 : 32'(r_planes);
        xv = 32'(r_col);
        yv = 32'(r_row);
        zv = 32'(r_plane);
        two  = er < 32'd3;
        idxv = yv * 32'(MAX_COLS) + xv;
        use_n = (zv >= 32'd2) && (xv >= 32'd1) && (xv + 32'd1 < ec) &&
                (two ? (yv == 32'd0) : ((yv >= 32'd1) && (yv + 32'd1 < er)));
        last_n = (zv + 32'd1 == ep) && (xv + 32'd2 == ec) &&
                 (yv == (two ? 32'd0 : er - 32'd2));
        d_ab = sdiff(r_a, r_rd, r_c);
        d_z  = sdiff(r_s, r_old, r_c);
        prod = r_d * r_d;
        case (i_cmd.addr)
            A_C:     raddr = r_idx;
            A_XP:    raddr = r_idx + AW'(1);
            A_XM:    raddr = r_idx - AW'(1);
            A_YP:    raddr = r_idx + AW'(MAX_COLS);
            A_YM:    raddr = r_idx - AW'(MAX_COLS);
            default: raddr = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd <= rmem[raddr];
        r_od <= omem[r_idx];
        if (i_cmd.mem_wr) begin
            rmem[r_idx] <= r_s;
            omem[r_idx] <= r_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols   <= COLS_RESET;
            r_rows   <= ROWS_RESET;
            r_planes <= PLANES_RESET;
            r_col    <= '0;
            r_row    <= '0;
            r_plane  <= '0;
            r_least  <= SUM_ONES;
            r_ov     <= 1'b0;
        end else begin
            if (i_valid_pop()) r_ov <= 1'b0;
            if (i_cfg_we && (i_cfg_idx == CFG_COLS || i_cfg_idx == CFG_ROWS ||
                             i_cfg_idx == CFG_PLANES)) begin
                case (i_cfg_idx)
                    CFG_COLS:   r_cols   <= i_cfg_data[GEOM_W-1:0];
                    CFG_ROWS:   r_rows   <= i_cfg_data[GEOM_W-1:0];
                    CFG_PLANES: r_planes <= i_cfg_data;
                    default:    r_cols   <= r_cols;
                endcase
                r_col   <= '0;
                r_row   <= '0;
                r_plane <= '0;
                r_least <= SUM_ONES;
            end else if (i_cmd.accept) begin
                if (xv + 32'd1 >= ec) begin
                    r_col <= '0;
                    if (yv + 32'd1 >= er) begin
                        r_row   <= '0;
                        r_plane <= (zv + 32'd1 >= ep) ? '0 : r_plane + 1'b1;
                    end else begin
                        r_row <= r_row + 1'b1;
                    end
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (i_cmd.min_wr && (r_sum < r_least)) r_least <= r_sum;
            if (i_cmd.load_out) begin
                r_ov <= 1'b1;
                if (r_last) r_least <= SUM_ONES;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_s    <= i_sample;
            r_idx  <= AW'(idxv);
            r_use  <= use_n;
            r_last <= last_n;
            r_two  <= two;
        end
        if (i_cmd.lat_c) begin
            r_c   <= r_rd;
            r_old <= r_od;
        end
        if (i_cmd.lat_a) r_a <= r_rd;
        if (i_cmd.dx) r_d <= d_ab;
        if (i_cmd.dy) r_d <= r_two ? '0 : d_ab;
        if (i_cmd.dz) r_d <= d_z;
        if (i_cmd.sq) r_sq <= SUM_W'(prod);
        if (i_cmd.sum_init) r_sum <= r_sq;
        if (i_cmd.acc) r_sum <= r_sum + r_sq;
        if (i_cmd.lat_q) r_q <= root;
        if (i_cmd.lat_mq) r_mq <= root;
        if (i_cmd.load_out) begin
            r_oq  <= r_q;
            r_omq <= r_last ? r_mq : '0;
            r_of  <= r_last;
        end
    end

    psdq_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.root_start),
        .i_value (i_cmd.root_sel ? r_least : r_sum),
        .o_root  (root),
        .o_done  (root_done)
    );

    assign o_sts.use_v     = r_use;
    assign o_sts.last_v    = r_last;
    assign o_sts.root_done = root_done;
    assign o_sts.out_free  = !r_ov || i_ready;

    assign o_valid       = r_ov;
    assign o_quality     = r_oq;
    assign o_min_quality = r_omq;
    assign o_final_flag  = r_of;
endmodule

/* rtl/core/psdq_ctrl.sv */
// Controller: sequences store reads, arithmetic, roots and output hand-off.
// Depends on psdq_pkg.
module psdq_ctrl import psdq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_RC   = 15'b000000000000010,
        S_RXP  = 15'b000000000000100,
        S_WRN  = 15'b000000000001000,
        S_RXM  = 15'b000000000010000,
        S_RYP  = 15'b000000000100000,
        S_RYM  = 15'b000000001000000,
        S_DY   = 15'b000000010000000,
        S_SQZ  = 15'b000000100000000,
        S_ACC1 = 15'b000001000000000,
        S_ACC2 = 15'b000010000000000,
        S_MIN  = 15'b000100000000000,
        S_RT1  = 15'b001000000000000,
        S_RT2  = 15'b010000000000000,
        S_OUT  = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.addr = A_C;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = S_RC;
                end
            end
            S_RC: n_state = S_RXP;
            S_RXP: begin
                o_cmd.lat_c = 1'b1;
                o_cmd.addr  = A_XP;
                n_state = i_sts.use_v ? S_RXM : S_WRN;
            end
            S_WRN: begin
                o_cmd.mem_wr = 1'b1;
                n_state = S_IDLE;
            end
            S_RXM: begin
                o_cmd.lat_a = 1'b1;
                o_cmd.addr  = A_XM;
                n_state = S_RYP;
            end
            S_RYP: begin
                o_cmd.dx   = 1'b1;
                o_cmd.addr = A_YP;
                n_state = S_RYM;
            end
            S_RYM: begin
                o_cmd.sq    = 1'b1;
                o_cmd.lat_a = 1'b1;
                o_cmd.addr  = A_YM;
                n_state = S_DY;
            end
            S_DY: begin
                o_cmd.sum_init = 1'b1;
                o_cmd.dy       = 1'b1;
                n_state = S_SQZ;
            end
            S_SQZ: begin
                o_cmd.sq = 1'b1;
                o_cmd.dz = 1'b1;
                n_state = S_ACC1;
            end
            S_ACC1: begin
                o_cmd.acc = 1'b1;
                o_cmd.sq  = 1'b1;
                n_state = S_ACC2;
            end
            S_ACC2: begin
                o_cmd.acc = 1'b1;
                n_state = S_MIN;
            end
            S_MIN: begin
                o_cmd.min_wr     = 1'b1;
                o_cmd.mem_wr     = 1'b1;
                o_cmd.root_start = 1'b1;
                n_state = S_RT1;
            end
            S_RT1: begin
                if (i_sts.root_done) begin
                    o_cmd.lat_q = 1'b1;
                    if (i_sts.last_v) begin
                        o_cmd.root_start = 1'b1;
                        o_cmd.root_sel   = 1'b1;
                        n_state = S_RT2;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_RT2: begin
                if (i_sts.root_done) begin
                    o_cmd.lat_mq = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

/* tb/tb.sv */
// Self-checking testbench for phase_second_difference_quality.
// Depends on psdq_pkg, psdq_in_if, psdq_out_if and the block's RTL; streams voxel
// volumes of several geometries and checks every quality word against a predictor.
module tb;
    import psdq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int STORE_COLS = DEF_MAX_COLS;
    localparam int STORE_DEPTH = DEF_MAX_COLS * DEF_MAX_ROWS;
    localparam logic signed [SAMPLE_W-1:0] S_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = -24'sh800000;

    typedef struct packed {
        logic [Q_W-1:0] quality;
        logic [Q_W-1:0] min_quality;
        logic           final_flag;
    } t_quality_word;

    class quality_scoreboard;
        logic signed [SAMPLE_W-1:0] older[STORE_DEPTH];
        logic signed [SAMPLE_W-1:0] recent[STORE_DEPTH];
        int unsigned   cols, rows, planes;
        int unsigned   col_cnt, row_cnt, plane_cnt;
        logic [SUM_W-1:0] least;
        t_quality_word expected[$];
        int            errors;
        int            n_in;

        function new();
            foreach (older[i]) begin
                older[i]  = '0;
                recent[i] = '0;
            end
            cols   = COLS_RESET;
            rows   = ROWS_RESET;
            planes = PLANES_RESET;
            errors = 0;
            n_in   = 0;
            restart();
        endfunction

        function void restart();
            col_cnt   = 0;
            row_cnt   = 0;
            plane_cnt = 0;
            least     = '1;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_COLS:   cols   = d[GEOM_W-1:0];
                CFG_ROWS:   rows   = d[GEOM_W-1:0];
                CFG_PLANES: planes = d;
                default:    return;
            endcase
            restart();
        endfunction

        function longint unsigned sq_diff(longint a, longint b, longint c);
            longint d;
            d = a + b - 2 * c;
            return d * d;
        endfunction

        function logic [Q_W-1:0] root(longint unsigned v);
            longint unsigned r, t;
            r = 0;
            for (int b = Q_W - 1; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if (t * t <= v) r = t;
            end
            return r[Q_W-1:0];
        endfunction

        function void note_input(logic signed [SAMPLE_W-1:0] s);
            int unsigned ec, er, ep, x, y, z, idx;
            bit two_axis, use_it, last;
            longint unsigned sum;
            longint c;
            t_quality_word w;
            n_in++;
            ec = (cols < 1) ? 1 : (cols > DEF_MAX_COLS) ? DEF_MAX_COLS : cols;
            er = (rows < 1) ? 1 : (rows > DEF_MAX_ROWS) ? DEF_MAX_ROWS : rows;
            ep = (planes == 0) ? 1 : planes;
            x = col_cnt % ec;
            y = row_cnt % er;
            z = plane_cnt;
            two_axis = er < 3;
            idx = y * STORE_COLS + x;
            if (z >= 2 && x >= 1 && x + 1 < ec) begin
                use_it = 0;
                sum = 0;
                c = recent[idx];
                if (two_axis) begin
                    use_it = (y == 0);
                end else if (y >= 1 && y + 1 < er) begin
                    use_it = 1;
                    sum += sq_diff(recent[idx + STORE_COLS], recent[idx - STORE_COLS], c);
                end
                if (use_it) begin
                    sum += sq_diff(recent[idx + 1], recent[idx - 1], c);
                    sum += sq_diff(s, older[idx], c);
                    if (sum < least) least = sum;
                    last = (z + 1 == ep) && (x + 2 == ec) && (y == (two_axis ? 0 : er - 2));
                    w.quality     = root(sum);
                    w.min_quality = last ? root(least) : '0;
                    w.final_flag  = last;
                    if (last) least = '1;
                    expected.push_back(w);
                end
            end
            older[idx]  = recent[idx];
            recent[idx] = s;
            if (x + 1 >= ec) begin
                col_cnt = 0;
                if (y + 1 >= er) begin
                    row_cnt = 0;
                    plane_cnt = (z + 1 >= ep) ? 0 : z + 1;
                end else begin
                    row_cnt = y + 1;
                end
            end else begin
                col_cnt = x + 1;
                row_cnt = y;
            end
        endfunction

        function void check_result(t_quality_word got);
            t_quality_word w;
            if (expected.size() == 0) begin
                $error("unexpected quality word %h", got);
                errors++;
                return;
            end
            w = expected.pop_front();
            if (got.quality !== w.quality) begin
                $error("quality: expected %0d, got %0d", w.quality, got.quality);
                errors++;
            end
            if (got.min_quality !== w.min_quality) begin
                $error("min_quality: expected %0d, got %0d", w.min_quality, got.min_quality);
                errors++;
            end
            if (got.final_flag !== w.final_flag) begin
                $error("final_flag: expected %0d, got %0d", w.final_flag, got.final_flag);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    bit                    idling;
    int                    hold_cnt;
    bit                    held_once;

    psdq_in_if  in_ch ();
    psdq_out_if out_ch ();

    quality_scoreboard sb = new();

    phase_second_difference_quality i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch.sink),
        .o_out     (out_ch.source),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = CFG_COLS;
        i_cfg_data         = '0;
        in_ch.valid        = 1'b0;
        in_ch.phase_sample = '0;
        out_ch.ready       = 1'b0;
        idling             = 1'b1;
        hold_cnt           = 0;
        held_once          = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) sb.note_input(in_ch.phase_sample);
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result({out_ch.quality, out_ch.min_quality, out_ch.final_flag});
    end

    // hold off once for a long stretch so the block backs up onto its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            out_ch.ready <= 1'b0;
        end else if (!held_once && sb.n_in >= 210) begin
            held_once <= 1'b1;
            hold_cnt <= 400;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= !(idling && $urandom_range(99) < 35);
        end
    end

    task automatic write_geometry(int unsigned c, int unsigned r, int unsigned p);
        logic [CFG_DATA_W-1:0] vals[3];
        logic [CFG_IDX_W-1:0]  idxs[3];
        vals = '{c[CFG_DATA_W-1:0], r[CFG_DATA_W-1:0], p[CFG_DATA_W-1:0]};
        idxs = '{CFG_COLS, CFG_ROWS, CFG_PLANES};
        for (int k = 0; k < 3; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idxs[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            sb.write_reg(idxs[k], vals[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_word(logic signed [SAMPLE_W-1:0] v);
        while (idling && $urandom_range(99) < 35) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.phase_sample <= v;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 6) return SAMPLE_W'($urandom);
        if (pick < 8) return SAMPLE_W'($signed($urandom_range(2000)) - 1000);
        case ($urandom_range(2))
            0: return S_MAX;
            1: return S_MIN;
            default: return '0;
        endcase
    endfunction

    int unsigned geo[13][5] = '{
        '{5, 4, 4, 80, 1},
        '{3, 2, 4, 24, 1},
        '{32, 1, 3, 96, 0},
        '{7, 3, 3, 63, 1},
        '{100, 3, 3, 24, 1},
        '{16'hFF83, 3, 3, 27, 1},
        '{0, 3, 3, 10, 1},
        '{6, 0, 3, 18, 1},
        '{4, 3, 0, 12, 1},
        '{3, 64, 3, 24, 1},
        '{5, 3, 65535, 30, 1},
        '{2, 3, 3, 9, 1},
        '{3, 3, 2, 18, 1}
    };

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one interior voxel at full-scale swing
        write_geometry(3, 3, 3);
        for (int k = 0; k < 27; k++) send_word((k % 2) ? S_MIN : S_MAX);
        drain();
        write_geometry(4, 1, 3);
        for (int k = 0; k < 12; k++) send_word((k % 3 == 0) ? S_MAX : (k % 3 == 1) ? '0 : S_MIN);
        drain();

        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SPARE;
        i_cfg_data <= 16'hFFFF;
        @(posedge i_clk);
        sb.write_reg(CFG_SPARE, 16'hFFFF);
        i_cfg_we <= 1'b0;

        foreach (geo[g]) begin
            write_geometry(geo[g][0], geo[g][1], geo[g][2]);
            idling = geo[g][4] != 0;
            for (int k = 0; k < geo[g][3]; k++) send_word(random_sample());
            drain();
        end
        idling = 1'b1;

        if (sb.errors == 0 && sb.expected.size() == 0) begin
            $display("** phase_second_difference_quality: PASSED **");
        end else begin
            $display("** phase_second_difference_quality: FAILED **");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("** phase_second_difference_quality: FAILED **");
        $finish;
    end
endmodule
